[rtl/pfn_pkg.sv]
// ---------------------------------------------------------------------------
// pfn_pkg
// shared types and constants for the fbm gradient noise unit
// ---------------------------------------------------------------------------
package pfn_pkg;

  localparam int unsigned SeedW = 48;
  localparam logic [47:0] LcgMult = 48'h0005_DEEC_E66D;
  localparam logic [47:0] LcgAdd  = 48'h0000_0000_000B;

  localparam logic [1:0] RegSeed   = 2'd0;
  localparam logic [1:0] RegOctave = 2'd1;
  localparam logic [1:0] RegFreq   = 2'd2;

  localparam logic OpInit   = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_z;
  } pfn_in_t;

  typedef struct packed {
    logic signed [17:0] noise_value;
    logic               init_done;
  } pfn_out_t;

endpackage

[rtl/perlin_fbm_noise_2d_unit.sv]
// ---------------------------------------------------------------------------
// perlin_fbm_noise_2d_unit
// fractal 2-d gradient noise with a seeded permutation table
// ---------------------------------------------------------------------------
// in_valid/in_ready carry one transaction: op 0 rebuilds the permutation from
// cfg world_seed, op 1 samples noise at (coord_x, coord_z). Every transaction
// returns one result on out_valid/out_ready.
// One item at a time. Per octave of a sample the shared 33x33 multiplier runs
// the scale, fade and lerp products in sequence and the permutation ram (one
// port, registered read) is read six times. An init runs an identity fill of
// the table, then per shuffle step a 48-bit lcg step as three partial
// products, a bit-serial remainder of seed>>17 against i+1 and a ram swap
// through S_MODW, S_RDI, S_RDJ, S_WRI and S_WRJ.
// Reset: the table reads as zero until the first init; a clearing pass over
// all 256 entries after reset writes zeros while no transaction is accepted.
// Registers reset to seed 404, 6 octaves and frequency 3277.
// When the receiver stalls the result waits in the output register and
// no new transaction is taken until it is delivered.
// ---------------------------------------------------------------------------
module perlin_fbm_noise_2d_unit
  import pfn_pkg::*;
#(
  parameter int unsigned MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pfn_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pfn_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int unsigned OctW = $clog2(MAX_OCTAVES + 1) < 4 ? 4 : $clog2(MAX_OCTAVES + 1);

  typedef enum logic [21:0] {
    S_CLR   = 22'd1 << 0,
    S_IDLE  = 22'd1 << 1,
    S_INIT  = 22'd1 << 2,
    S_LCG   = 22'd1 << 3,
    S_MOD   = 22'd1 << 4,
    S_RDI   = 22'd1 << 5,
    S_RDJ   = 22'd1 << 6,
    S_WRI   = 22'd1 << 7,
    S_WRJ   = 22'd1 << 8,
    S_OCT   = 22'd1 << 9,
    S_SCL   = 22'd1 << 10,
    S_FADE  = 22'd1 << 11,
    S_RDC   = 22'd1 << 12,
    S_RDG   = 22'd1 << 13,
    S_LRP   = 22'd1 << 14,
    S_ACC   = 22'd1 << 15,
    S_FIN   = 22'd1 << 16,
    S_OUT   = 22'd1 << 17,
    S_WAIT  = 22'd1 << 18,
    S_RDC2  = 22'd1 << 19,
    S_LCGW  = 22'd1 << 20,
    S_MODW  = 22'd1 << 21
  } st_t;

  st_t st_r, st_nxt;

  // configuration
  logic [47:0] seed_cfg_r;
  logic [3:0]  oct_cfg_r;
  logic [15:0] freq_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_cfg_r <= 48'd404;
      oct_cfg_r  <= 4'd6;
      freq_cfg_r <= 16'd3277;
    end else if (cfg_we) begin
      case (cfg_index)
        RegSeed:   seed_cfg_r <= cfg_data;
        RegOctave: oct_cfg_r  <= cfg_data[3:0];
        RegFreq:   freq_cfg_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // shared signed multiplier (33x33 signed covers 32-bit operands + sign)
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  assign mp = ma * mb;

  // ram
  logic       ram_we;
  logic [7:0] ram_addr, ram_wdata, ram_rdata;

  pfn_ram #(.WIDTH(8), .DEPTH(256)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // working registers
  logic [8:0]  cnt_r, cnt_nxt;            // clear index / shuffle i
  logic [4:0]  sub_r, sub_nxt;            // step counter within a phase
  logic [47:0] lcg_r, lcg_nxt;
  logic [47:0] acc48_r, acc48_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [7:0]  pi_r, pi_nxt, pj_r, pj_nxt;
  logic        op_r, op_nxt;
  logic signed [31:0] cx_r, cx_nxt, cz_r, cz_nxt;
  logic [OctW-1:0] oct_r, oct_nxt, noct_r, noct_nxt;
  logic [31:0] f_r, f_nxt;                // base_frequency << octave
  logic [7:0]  celx_r, celx_nxt, celz_r, celz_nxt;
  logic signed [17:0] fx_r, fx_nxt, fz_r, fz_nxt;
  logic signed [35:0] t_r [4];
  logic signed [35:0] t_nxt [4];
  logic [7:0]  ha_r, ha_nxt, hb_r, hb_nxt;
  logic [1:0]  h_r [4];
  logic [1:0]  h_nxt [4];
  logic signed [35:0] sum_r, sum_nxt;
  pfn_out_t res_r, res_nxt;

  function automatic logic signed [35:0] sra16(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = v >>> 16;
    return s[35:0];
  endfunction

  function automatic logic signed [35:0] gradf(input logic [1:0] h,
                                               input logic signed [35:0] x,
                                               input logic signed [35:0] z);
    case (h)
      2'd0:    return x + z;
      2'd1:    return z - x;
      2'd2:    return x - z;
      default: return -x - z;
    endcase
  endfunction

  localparam logic signed [35:0] One = 36'sd65536;

  logic [8:0] ip1;
  assign ip1 = cnt_r + 9'd1;

  always_comb begin
    logic signed [35:0] gx, gz, d;
    logic [24:0] trial;
    st_nxt = st_r;
    cnt_nxt = cnt_r; sub_nxt = sub_r; lcg_nxt = lcg_r; acc48_nxt = acc48_r;
    rem_nxt = rem_r; pi_nxt = pi_r; pj_nxt = pj_r; op_nxt = op_r;
    cx_nxt = cx_r; cz_nxt = cz_r; oct_nxt = oct_r; noct_nxt = noct_r; f_nxt = f_r;
    celx_nxt = celx_r; celz_nxt = celz_r; fx_nxt = fx_r; fz_nxt = fz_r;
    ha_nxt = ha_r; hb_nxt = hb_r; sum_nxt = sum_r; res_nxt = res_r;
    for (int k = 0; k < 4; k++) begin
      t_nxt[k] = t_r[k];
      h_nxt[k] = h_r[k];
    end
    ma = '0; mb = '0;
    ram_we = 1'b0; ram_addr = '0; ram_wdata = '0;
    in_ready = 1'b0;
    gx = '0; gz = '0; d = '0; trial = '0;

    case (st_r)
      S_CLR: begin
        ram_we = 1'b1;
        ram_addr = cnt_r[7:0];
        cnt_nxt = cnt_r + 9'd1;
        if (cnt_r == 9'd255) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt = in_data.op;
          cx_nxt = in_data.coord_x;
          cz_nxt = in_data.coord_z;
          if (in_data.op == OpInit) begin
            cnt_nxt = '0;
            st_nxt = S_INIT;
          end else begin
            sum_nxt = '0;
            oct_nxt = '0;
            f_nxt = {16'd0, freq_cfg_r};
            if (oct_cfg_r == 4'd0) noct_nxt = OctW'(1);
            else if (OctW'(oct_cfg_r) > OctW'(MAX_OCTAVES)) noct_nxt = OctW'(MAX_OCTAVES);
            else noct_nxt = OctW'(oct_cfg_r);
            st_nxt = S_SCL;
            sub_nxt = '0;
          end
        end
      end
      // ---------------- init: fisher-yates over ram ----------------
      S_INIT: begin
        // the shuffle starts from the identity permutation
        ram_we = 1'b1;
        ram_addr = cnt_r[7:0];
        ram_wdata = cnt_r[7:0];
        cnt_nxt = cnt_r + 9'd1;
        if (cnt_r == 9'd255) begin
          lcg_nxt = seed_cfg_r ^ LcgMult;
          cnt_nxt = 9'd255;
          st_nxt = S_LCG;
          sub_nxt = '0;
        end
      end
      S_LCG: begin
        // seed*mult + add mod 2^48 as three partial products
        case (sub_r)
          5'd0: begin
            ma = {1'b0, lcg_r[31:0]}; mb = {1'b0, LcgMult[31:0]};
            acc48_nxt = mp[47:0] + LcgAdd;
          end
          5'd1: begin
            ma = {17'd0, lcg_r[47:32]}; mb = {1'b0, LcgMult[31:0]};
            acc48_nxt = acc48_r + {mp[15:0], 32'd0};
          end
          default: begin
            ma = {1'b0, lcg_r[31:0]}; mb = {17'd0, LcgMult[47:32]};
            acc48_nxt = acc48_r + {mp[15:0], 32'd0};
          end
        endcase
        sub_nxt = sub_r + 5'd1;
        if (sub_r == 5'd2) st_nxt = S_LCGW;
      end
      S_LCGW: begin
        lcg_nxt = acc48_r;
        rem_nxt = '0;
        sub_nxt = 5'd30;
        st_nxt = S_MOD;
      end
      S_MOD: begin
        // restoring remainder, one bit of (seed>>17) per cycle
        trial = {rem_r, lcg_r[17 + sub_r]};
        if (trial >= {16'd0, ip1}) rem_nxt = 24'(trial - {16'd0, ip1});
        else rem_nxt = trial[23:0];
        sub_nxt = sub_r - 5'd1;
        if (sub_r == 5'd0) st_nxt = S_MODW;
      end
      S_MODW: begin
        ram_addr = cnt_r[7:0];
        st_nxt = S_RDI;
      end
      S_RDI: begin
        pi_nxt = ram_rdata;
        ram_addr = rem_r[7:0];
        st_nxt = S_RDJ;
      end
      S_RDJ: begin
        pj_nxt = ram_rdata;
        st_nxt = S_WRI;
      end
      S_WRI: begin
        ram_we = 1'b1; ram_addr = rem_r[7:0]; ram_wdata = pi_r;
        st_nxt = S_WRJ;
      end
      S_WRJ: begin
        ram_we = 1'b1; ram_addr = cnt_r[7:0]; ram_wdata = pj_r;
        sub_nxt = '0;
        if (cnt_r == 9'd0) begin
          res_nxt.noise_value = '0;
          res_nxt.init_done = 1'b1;
          st_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r - 9'd1;
          st_nxt = S_LCG;
        end
      end
      // ---------------- sample ----------------
      S_SCL: begin
        // sub 0: x*f, sub 1: z*f
        mb = {1'b0, f_r};
        ma = (sub_r == 5'd0) ? {cx_r[31], cx_r} : {cz_r[31], cz_r};
        if (sub_r == 5'd0) begin
          celx_nxt = mp[39:32];
          fx_nxt = {2'b00, mp[31:16]};
        end else begin
          celz_nxt = mp[39:32];
          fz_nxt = {2'b00, mp[31:16]};
        end
        sub_nxt = sub_r + 5'd1;
        if (sub_r == 5'd1) begin
          sub_nxt = '0;
          st_nxt = S_FADE;
        end
      end
      S_FADE: begin
        // t_r[0..1]: fade x in progress, t_r[2..3]: fade z
        // steps per axis: t2=t*t, t3=t2*t, in1=t*(6t-15), t3*(in1+10)
        case (sub_r[2:0])
          3'd0, 3'd4: begin
            gx = sub_r[2] ? 36'(fz_r) : 36'(fx_r);
            ma = 33'(gx); mb = 33'(gx);
            t_nxt[{sub_r[2], 1'b0}] = sra16(mp);
          end
          3'd1, 3'd5: begin
            gx = sub_r[2] ? 36'(fz_r) : 36'(fx_r);
            ma = 33'(t_r[{sub_r[2], 1'b0}]); mb = 33'(gx);
            t_nxt[{sub_r[2], 1'b0}] = sra16(mp);
          end
          3'd2, 3'd6: begin
            gx = sub_r[2] ? 36'(fz_r) : 36'(fx_r);
            ma = 33'(gx); mb = 33'(36'(gx * 6) - 15 * One);
            t_nxt[{sub_r[2], 1'b1}] = sra16(mp) + 10 * One;
          end
          default: begin
            ma = 33'(t_r[{sub_r[2], 1'b0}]); mb = 33'(t_r[{sub_r[2], 1'b1}]);
            t_nxt[{sub_r[2], 1'b0}] = sra16(mp);
          end
        endcase
        sub_nxt = sub_r + 5'd1;
        if (sub_r == 5'd7) begin
          sub_nxt = '0;
          st_nxt = S_RDC;
        end
      end
      S_RDC: begin
        // read p[cx], p[cx+1]
        ram_addr = (sub_r == 5'd0) ? celx_r : celx_r + 8'd1;
        if (sub_r == 5'd1) ha_nxt = ram_rdata + celz_r;
        sub_nxt = sub_r + 5'd1;
        if (sub_r == 5'd1) st_nxt = S_RDC2;
      end
      S_RDC2: begin
        hb_nxt = ram_rdata + celz_r;
        ram_addr = ha_r;
        sub_nxt = '0;
        st_nxt = S_RDG;
      end
      S_RDG: begin
        // read order: a, b, a+1, b+1 -> h[0..3]
        case (sub_r[1:0])
          2'd0:    ram_addr = hb_r;
          2'd1:    ram_addr = ha_r + 8'd1;
          default: ram_addr = hb_r + 8'd1;
        endcase
        h_nxt[sub_r[1:0]] = ram_rdata[1:0];
        sub_nxt = sub_r + 5'd1;
        if (sub_r == 5'd3) begin
          sub_nxt = '0;
          st_nxt = S_LRP;
        end
      end
      S_LRP: begin
        // t_r[0]=u, t_r[2]=v ; t_r[1]=lo, t_r[3]=hi
        case (sub_r[1:0])
          2'd0: begin
            gx = gradf(h_r[0], 36'(fx_r), 36'(fz_r));
            gz = gradf(h_r[1], 36'(fx_r) - One, 36'(fz_r));
            d = gz - gx;
            ma = 33'(t_r[0]); mb = 33'(d);
            t_nxt[1] = gx + sra16(mp);
          end
          2'd1: begin
            gx = gradf(h_r[2], 36'(fx_r), 36'(fz_r) - One);
            gz = gradf(h_r[3], 36'(fx_r) - One, 36'(fz_r) - One);
            d = gz - gx;
            ma = 33'(t_r[0]); mb = 33'(d);
            t_nxt[3] = gx + sra16(mp);
          end
          default: begin
            d = t_r[3] - t_r[1];
            ma = 33'(t_r[2]); mb = 33'(d);
            t_nxt[1] = t_r[1] + sra16(mp);
          end
        endcase
        sub_nxt = sub_r + 5'd1;
        if (sub_r == 5'd2) st_nxt = S_ACC;
      end
      S_ACC: begin
        sum_nxt = sum_r + (t_r[1] >>> oct_r);
        oct_nxt = oct_r + OctW'(1);
        f_nxt = f_r << 1;
        sub_nxt = '0;
        if (oct_r + OctW'(1) == noct_r) st_nxt = S_FIN;
        else st_nxt = S_SCL;
      end
      S_FIN: begin
        d = (sum_r + One) >>> 1;
        if (d > 36'sd131071) res_nxt.noise_value = 18'sd131071;
        else if (d < -36'sd131072) res_nxt.noise_value = -18'sd131072;
        else res_nxt.noise_value = d[17:0];
        res_nxt.init_done = 1'b0;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        st_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (out_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign out_valid = (st_r == S_WAIT);
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLR;
      cnt_r <= '0;
      sub_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      sub_r <= sub_nxt;
    end
    lcg_r <= lcg_nxt; acc48_r <= acc48_nxt; rem_r <= rem_nxt;
    pi_r <= pi_nxt; pj_r <= pj_nxt; op_r <= op_nxt;
    cx_r <= cx_nxt; cz_r <= cz_nxt; oct_r <= oct_nxt; noct_r <= noct_nxt;
    f_r <= f_nxt; celx_r <= celx_nxt; celz_r <= celz_nxt;
    fx_r <= fx_nxt; fz_r <= fz_nxt; ha_r <= ha_nxt; hb_r <= hb_nxt;
    sum_r <= sum_nxt; res_r <= res_nxt;
    for (int k = 0; k < 4; k++) begin
      t_r[k] <= t_nxt[k];
      h_r[k] <= h_nxt[k];
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_init_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.init_done |-> out_data.noise_value == 18'sd0)
    else $error("init result carries noise");
  a_clr_ready: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_CLR |-> !in_ready)
    else $error("accepted during clearing pass");
`endif

endmodule

[rtl/pfn_ram.sv]
// ---------------------------------------------------------------------------
// pfn_ram
// generic single-port ram, registered read
// ---------------------------------------------------------------------------
module pfn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
